@@ hdl/qra_pkg.sv @@
// Package for the QoS requirement aggregator: codes, word types and the fold function.
package qra_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] CLS_NONE     = 2'd0;
    localparam logic [1:0] CLS_CPU_LAT  = 2'd1;
    localparam logic [1:0] CLS_NET_LAT  = 2'd2;
    localparam logic [1:0] CLS_NET_TPUT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;
    localparam logic [1:0] ST_BAD_CLS  = 2'd3;

    localparam int         CFG_IDX_W       = 2;
    localparam int         CFG_DATA_W      = 31;
    localparam logic [1:0] REG_DEF_CPU_LAT = 2'd0;
    localparam logic [1:0] REG_DEF_NET_LAT = 2'd1;
    localparam logic [1:0] REG_DEF_NET_TP  = 2'd2;

    // 2000 seconds expressed in microseconds.
    localparam logic [CFG_DATA_W-1:0] DEF_LAT_RESET = 31'd2000000000;
    localparam logic [CFG_DATA_W-1:0] DEF_TP_RESET  = 31'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ADD,
        WR_UPD,
        WR_REM
    } wr_op_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         qos_class;
        logic [7:0]         req_id;
        logic signed [31:0] req_value;
        logic               use_default;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] agg_value;
        logic               target_changed;
    } out_word_t;

    // Operation broadcast to every cell: the scan key and, for one cycle, a table write.
    typedef struct packed {
        wr_op_t             kind;
        logic [1:0]         cls;
        logic [7:0]         id;
        logic signed [31:0] val;
    } slot_op_t;

    // Token that walks the chain. ext holds the extreme over the class default and every
    // slot of the class except the newest id match seen so far, which is kept apart.
    typedef struct packed {
        logic               free_found;
        logic               match_found;
        logic signed [31:0] match_value;
        logic signed [31:0] ext;
    } scan_tok_t;

    function automatic logic signed [31:0] fold(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic               is_max);
        logic signed [31:0] r;
        if (is_max) begin
            r = (b > a) ? b : a;
        end else begin
            r = (b < a) ? b : a;
        end
        return r;
    endfunction

endpackage

@@ hdl/qra_cell.sv @@
// One table slot of the aggregator chain with its stage of the scan token.
module qra_cell #(
    parameter int IDX_W  = 5,
    parameter int MY_IDX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qra_pkg::slot_op_t     op,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [IDX_W-1:0]      wr_gone,
    input  qra_pkg::scan_tok_t    tok_in,
    input  logic [IDX_W-1:0]      free_idx_in,
    input  logic [IDX_W-1:0]      match_idx_in,
    input  logic [IDX_W-1:0]      match_age_in,
    output qra_pkg::scan_tok_t    tok_out,
    output logic [IDX_W-1:0]      free_idx_out,
    output logic [IDX_W-1:0]      match_idx_out,
    output logic [IDX_W-1:0]      match_age_out
);
    import qra_pkg::*;

    localparam logic [IDX_W-1:0] ME = IDX_W'(MY_IDX);

    logic               valid_reg, valid_next;
    logic [1:0]         class_reg, class_next;
    logic [7:0]         id_reg, id_next;
    logic signed [31:0] value_reg, value_next;
    logic [IDX_W-1:0]   age_reg, age_next;

    scan_tok_t          tok_reg, tok_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic [IDX_W-1:0]   midx_reg, midx_next;
    logic [IDX_W-1:0]   mage_reg, mage_next;

    logic hit, id_hit, better, is_max;

    // Scan stage.
    always_comb begin
        is_max    = (op.cls == CLS_NET_TPUT);
        hit       = valid_reg && (class_reg == op.cls);
        id_hit    = hit && (id_reg == op.id);
        better    = id_hit && (!tok_in.match_found || (age_reg < match_age_in));
        tok_next  = tok_in;
        fidx_next = free_idx_in;
        midx_next = match_idx_in;
        mage_next = match_age_in;
        if (!valid_reg && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            fidx_next           = ME;
        end
        if (better) begin
            // The previous best match rejoins the general extreme.
            if (tok_in.match_found) begin
                tok_next.ext = fold(tok_in.ext, tok_in.match_value, is_max);
            end
            tok_next.match_found = 1'b1;
            tok_next.match_value = value_reg;
            midx_next            = ME;
            mage_next            = age_reg;
        end else if (hit) begin
            tok_next.ext = fold(tok_in.ext, value_reg, is_max);
        end
    end

    // Slot write.
    always_comb begin
        valid_next = valid_reg;
        class_next = class_reg;
        id_next    = id_reg;
        value_next = value_reg;
        age_next   = age_reg;
        case (op.kind)
            WR_ADD: begin
                if (valid_reg) begin
                    age_next = age_reg + 1'b1;
                end
                if (wr_idx == ME) begin
                    valid_next = 1'b1;
                    class_next = op.cls;
                    id_next    = op.id;
                    value_next = op.val;
                    age_next   = '0;
                end
            end
            WR_UPD: begin
                if (wr_idx == ME) begin
                    value_next = op.val;
                end
            end
            WR_REM: begin
                if (wr_idx == ME) begin
                    valid_next = 1'b0;
                end else if (valid_reg && (age_reg > wr_gone)) begin
                    age_next = age_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        class_reg <= class_next;
        id_reg    <= id_next;
        value_reg <= value_next;
        age_reg   <= age_next;
        tok_reg   <= tok_next;
        fidx_reg  <= fidx_next;
        midx_reg  <= midx_next;
        mage_reg  <= mage_next;
    end

    assign tok_out       = tok_reg;
    assign free_idx_out  = fidx_reg;
    assign match_idx_out = midx_reg;
    assign match_age_out = mage_reg;

endmodule

@@ hdl/qos_requirement_aggregator.sv @@
// QoS requirement aggregator: request table as a chain of slot cells plus sequencer.
// A word is accepted only while idle; the scan token then walks once through the chain of
// TABLE_DEPTH slot cells and the change is applied, while a bad class goes straight to apply.
// The result is registered, and apply waits until the output word is free.
// Reset empties the table and restores the three defaults and class targets.
module qos_requirement_aggregator #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  qra_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output qra_pkg::out_word_t                  m_data,
    input  logic                                cfg_we,
    input  logic [qra_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qra_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import qra_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         cmd_reg;
    logic [1:0]         cls_reg;
    logic [7:0]         id_reg;
    logic signed [31:0] val_reg;

    logic [CFG_DATA_W-1:0] dflt_cpu_reg, dflt_net_reg, dflt_tp_reg;
    logic signed [31:0]    tgt_cpu_reg, tgt_net_reg, tgt_tp_reg;

    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    logic               accept, out_free, commit;
    logic [CFG_DATA_W-1:0] in_dflt, cur_dflt;
    logic signed [31:0] cur_tgt, new_tgt, all_ext;
    logic [1:0]         status_c;
    logic               do_change, is_max;

    slot_op_t          op;
    logic [IDX_W-1:0]  wr_idx, wr_gone;
    scan_tok_t         tok  [0:TABLE_DEPTH];
    logic [IDX_W-1:0]  fidx [0:TABLE_DEPTH];
    logic [IDX_W-1:0]  midx [0:TABLE_DEPTH];
    logic [IDX_W-1:0]  mage [0:TABLE_DEPTH];
    scan_tok_t         tok_end;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        case (s_data.qos_class)
            CLS_CPU_LAT: in_dflt = dflt_cpu_reg;
            CLS_NET_LAT: in_dflt = dflt_net_reg;
            default:     in_dflt = dflt_tp_reg;
        endcase
        case (cls_reg)
            CLS_CPU_LAT: begin
                cur_dflt = dflt_cpu_reg;
                cur_tgt  = tgt_cpu_reg;
            end
            CLS_NET_LAT: begin
                cur_dflt = dflt_net_reg;
                cur_tgt  = tgt_net_reg;
            end
            CLS_NET_TPUT: begin
                cur_dflt = dflt_tp_reg;
                cur_tgt  = tgt_tp_reg;
            end
            default: begin
                cur_dflt = dflt_tp_reg;
                cur_tgt  = '0;
            end
        endcase
    end

    // Scan chain. The token enters with the class default as the starting extreme.
    assign tok[0]  = '{free_found: 1'b0, match_found: 1'b0, match_value: 32'sd0,
                       ext: $signed({1'b0, cur_dflt})};
    assign fidx[0] = '0;
    assign midx[0] = '0;
    assign mage[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        qra_cell #(
            .IDX_W  (IDX_W),
            .MY_IDX (g)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .op            (op),
            .wr_idx        (wr_idx),
            .wr_gone       (wr_gone),
            .tok_in        (tok[g]),
            .free_idx_in   (fidx[g]),
            .match_idx_in  (midx[g]),
            .match_age_in  (mage[g]),
            .tok_out       (tok[g+1]),
            .free_idx_out  (fidx[g+1]),
            .match_idx_out (midx[g+1]),
            .match_age_out (mage[g+1])
        );
    end

    assign tok_end = tok[TABLE_DEPTH];

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        op.kind      = WR_NONE;
        op.cls       = cls_reg;
        op.id        = id_reg;
        op.val       = val_reg;
        wr_idx       = '0;
        wr_gone      = mage[TABLE_DEPTH];
        commit       = 1'b0;
        status_c     = ST_OK;
        do_change    = 1'b0;
        is_max       = (cls_reg == CLS_NET_TPUT);
        all_ext      = tok_end.match_found ?
                       fold(tok_end.ext, tok_end.match_value, is_max) : tok_end.ext;
        new_tgt      = cur_tgt;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    state_next = (s_data.qos_class == CLS_NONE) ? ST_APPLY : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (cls_reg == CLS_NONE) begin
                    status_c = ST_BAD_CLS;
                    new_tgt  = '0;
                end else begin
                    case (cmd_reg)
                        CMD_ADD: begin
                            if (!tok_end.free_found) begin
                                status_c = ST_FULL;
                            end else begin
                                do_change = 1'b1;
                                op.kind   = WR_ADD;
                                wr_idx    = fidx[TABLE_DEPTH];
                                new_tgt   = fold(all_ext, val_reg, is_max);
                            end
                        end
                        CMD_UPDATE: begin
                            if (!tok_end.match_found) begin
                                status_c = ST_NO_MATCH;
                            end else begin
                                do_change = 1'b1;
                                op.kind   = WR_UPD;
                                wr_idx    = midx[TABLE_DEPTH];
                                new_tgt   = fold(tok_end.ext, val_reg, is_max);
                            end
                        end
                        CMD_REMOVE: begin
                            if (!tok_end.match_found) begin
                                status_c = ST_NO_MATCH;
                            end else begin
                                do_change = 1'b1;
                                op.kind   = WR_REM;
                                wr_idx    = midx[TABLE_DEPTH];
                                new_tgt   = tok_end.ext;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (out_free) begin
                    commit       = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: status_c, agg_value: new_tgt,
                                     target_changed: do_change && (new_tgt != cur_tgt)};
                    state_next   = ST_IDLE;
                end else begin
                    // Hold the table untouched until the output word is free.
                    op.kind = WR_NONE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            dflt_cpu_reg <= DEF_LAT_RESET;
            dflt_net_reg <= DEF_LAT_RESET;
            dflt_tp_reg  <= DEF_TP_RESET;
            tgt_cpu_reg  <= $signed({1'b0, DEF_LAT_RESET});
            tgt_net_reg  <= $signed({1'b0, DEF_LAT_RESET});
            tgt_tp_reg   <= $signed({1'b0, DEF_TP_RESET});
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEF_CPU_LAT: dflt_cpu_reg <= cfg_wdata;
                    REG_DEF_NET_LAT: dflt_net_reg <= cfg_wdata;
                    REG_DEF_NET_TP:  dflt_tp_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (commit && do_change) begin
                case (cls_reg)
                    CLS_CPU_LAT: tgt_cpu_reg <= new_tgt;
                    CLS_NET_LAT: tgt_net_reg <= new_tgt;
                    CLS_NET_TPUT: tgt_tp_reg <= new_tgt;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            cmd_reg <= s_data.cmd;
            cls_reg <= s_data.qos_class;
            id_reg  <= s_data.req_id;
            val_reg <= s_data.use_default ? $signed({1'b0, in_dflt}) : s_data.req_value;
        end
    end

endmodule
